>>> sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RARP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define RARP_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rarp_pkg.sv
// Shared constants, types and command/status structs of the range add / predecessor block.
package rarp_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ELEM_W = 48;

  typedef enum logic [CMD_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [ELEM_W-1:0] elem_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch range and operand, clear the running best
    logic add_op;    // with start: the scan writes back the saturated sum
    logic step;      // issue a read at the scan index and advance it
    logic wr_load;   // write the incoming element
    logic load_out;  // move the query result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;     // incoming range holds no element
    logic last;      // scan index sits on the range end
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

>>> sv/rarp_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface rarp_in_if;
  logic                                valid;
  logic                                ready;
  logic [rarp_pkg::CMD_W-1:0]          command;
  logic [rarp_pkg::IDX_W-1:0]          left;
  logic [rarp_pkg::IDX_W-1:0]          right;
  logic signed [rarp_pkg::VAL_W-1:0]   value;

  modport source (output valid, command, left, right, value, input ready);
  modport sink   (input valid, command, left, right, value, output ready);
endinterface

interface rarp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rarp_pkg::ELEM_W-1:0]  answer;
  logic                                found;

  modport source (output valid, answer, found, input ready);
  modport sink   (input valid, answer, found, output ready);
endinterface

>>> sv/range_add_range_predecessor.sv
// Top level of the range add / range predecessor query block.
//
// Input channel (in_if): one transaction carries command, left, right and value.
//   Load writes value at index left. Range add adds value to every
//   element of left..right (right clipped to the last index), saturating at the
//   48-bit signed range. Query returns the largest element of left..right that
//   lies strictly below value, with found, on the result channel (out_if).
// Load and range add return nothing; command 3 is dropped.
// Timing: one element memory with one read and one write port is swept one
//   element per cycle. A load or an empty range add keeps in_ready high. A
//   range add drops in_ready while it scans its range, a query also while
//   its result waits for the result register; an empty query skips the scan
//   and goes straight to the result register.
// The result sits in an output register: a stalled receiver does not stop
//   loads or range adds; a query waits at its end until the register frees.
// Reset (synchronous, rst_n low) clears the control state and the output
//   valid; the element memory is not cleared and an element must be loaded
//   before a range add or query reads it.
module range_add_range_predecessor (
  input  logic              clk,
  input  logic              rst_n,
  rarp_in_if.sink           in_if,
  rarp_out_if.source        out_if
);

  rarp_pkg::dp_cmd_t  cmd;
  rarp_pkg::dp_stat_t stat;

  rarp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rarp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_left    (in_if.left),
    .in_right   (in_if.right),
    .in_value   (in_if.value),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_answer (out_if.answer),
    .out_found  (out_if.found)
  );

endmodule

>>> sv/rarp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module rarp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> sv/rarp_ctrl.sv
// Controller state machine: sequences loads, range scans and result hand-off.
module rarp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [rarp_pkg::CMD_W-1:0] in_command,
  output logic                       in_ready,
  input  rarp_pkg::dp_stat_t         stat,
  output rarp_pkg::dp_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   is_query_r, is_query_nxt;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;

  // Decode next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    is_query_nxt = is_query_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            rarp_pkg::OP_LOAD: begin
              cmd.wr_load = 1'b1;
            end
            rarp_pkg::OP_ADD: begin
              if (!stat.empty) begin
                cmd.start    = 1'b1;
                cmd.add_op   = 1'b1;
                is_query_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            rarp_pkg::OP_QUERY: begin
              cmd.start    = 1'b1;
              is_query_nxt = 1'b1;
              state_nxt    = stat.empty ? ST_OUT : ST_SCAN;
            end
            default: begin
              // reserved command: drop
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // final element is processed in this cycle
        state_nxt = is_query_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      is_query_r <= 1'b0;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      is_query_r <= is_query_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

>>> sv/rarp_dp.sv
// Datapath: element memory, scan index, saturating adder, predecessor compare, result register.
module rarp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rarp_pkg::dp_cmd_t                 cmd,
  output rarp_pkg::dp_stat_t                stat,
  input  logic [rarp_pkg::IDX_W-1:0]        in_left,
  input  logic [rarp_pkg::IDX_W-1:0]        in_right,
  input  logic signed [rarp_pkg::VAL_W-1:0] in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output rarp_pkg::elem_t                   out_answer,
  output logic                              out_found
);

  localparam int ELEM_W = rarp_pkg::ELEM_W;
  localparam int VAL_W  = rarp_pkg::VAL_W;
  localparam int ADDR_W = rarp_pkg::ADDR_W;
  localparam logic [31:0] MAX32 = 32'(rarp_pkg::MAX_ELEMENTS);

  localparam rarp_pkg::elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam rarp_pkg::elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [31:0]                left_ext;
  logic                       left_ok;
  rarp_pkg::addr_t            right_clip;

  rarp_pkg::addr_t            idx_r;
  rarp_pkg::addr_t            right_r;
  logic signed [VAL_W-1:0]    value_r;
  logic                       is_add_r;
  logic                       proc_vld_r;
  rarp_pkg::addr_t            proc_addr_r;
  rarp_pkg::elem_t            best_r;
  logic                       found_r;
  logic                       out_valid_r;
  rarp_pkg::elem_t            answer_r;
  logic                       found_out_r;

  rarp_pkg::elem_t            rd_data;
  rarp_pkg::elem_t            value_ext;
  logic [ELEM_W:0]            sum;
  rarp_pkg::elem_t            sat_sum;
  logic                       below;
  logic                       better;
  logic                       wr_en;
  rarp_pkg::addr_t            wr_addr;
  rarp_pkg::elem_t            wr_data;

  // Clip the incoming range and flag an empty one
  always_comb begin
    left_ext = 32'(in_left);
    left_ok  = left_ext < MAX32;
    if (32'(in_right) >= MAX32) begin
      right_clip = ADDR_W'(rarp_pkg::MAX_ELEMENTS - 1);
    end else begin
      right_clip = ADDR_W'(in_right);
    end
  end

  // Report range and output status to the controller
  always_comb begin
    stat.empty    = !left_ok || (left_ext > 32'(right_clip));
    stat.last     = (idx_r == right_r);
    stat.out_free = !out_valid_r || out_ready;
  end

  // Saturating add of the operand to the element read back
  assign value_ext = {{(ELEM_W-VAL_W){value_r[VAL_W-1]}}, value_r};
  assign sum       = {rd_data[ELEM_W-1], rd_data} + {value_ext[ELEM_W-1], value_ext};

  always_comb begin
    if (sum[ELEM_W] != sum[ELEM_W-1]) begin
      sat_sum = sum[ELEM_W] ? ELEM_MIN : ELEM_MAX;
    end else begin
      sat_sum = sum[ELEM_W-1:0];
    end
  end

  // Predecessor compare against the bound and the running best
  assign below  = rd_data < value_ext;
  assign better = !found_r || (rd_data > best_r);

  // Select the write: a load from the input, else the add write-back
  assign wr_en   = (cmd.wr_load && left_ok) || (proc_vld_r && is_add_r);
  assign wr_addr = cmd.wr_load ? ADDR_W'(in_left) : proc_addr_r;
  assign wr_data = cmd.wr_load ? rarp_pkg::elem_t'(in_value) : sat_sum;

  rarp_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (rarp_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.step),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Latch the operation and advance the scan index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r    <= ADDR_W'(in_left);
      right_r  <= right_clip;
      value_r  <= in_value;
      is_add_r <= cmd.add_op;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
    proc_addr_r <= idx_r;
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= cmd.step;
    end
  end

  // Accumulate the largest element below the bound
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (proc_vld_r && !is_add_r && below && better) begin
      found_r <= 1'b1;
      best_r  <= rd_data;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      answer_r    <= found_r ? best_r : '0;
      found_out_r <= found_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;
  assign out_found  = found_out_r;

endmodule

>>> sv/rarp_checker.sv
// Port-level checker for the range add / predecessor block, bound to its top level.
`include "assert_macros.svh"

module rarp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [rarp_pkg::CMD_W-1:0]        in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [rarp_pkg::ELEM_W-1:0] out_answer,
  input logic                              out_found
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // A stalled result holds
  `RARP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_answer) && $stable(out_found), "result changed while stalled")

  // A miss reports zero
  `RARP_ASSERT(a_miss_zero, !(out_valid && !out_found) || (out_answer == '0), "miss with nonzero answer")

  // A load leaves the input ready in the next cycle
  `RARP_ASSERT_NEXT(a_load_fast, in_xfer && (in_command == rarp_pkg::OP_LOAD), in_ready, "load stalled the input")

  // A query always occupies the block past its accept cycle
  `RARP_ASSERT_NEXT(a_query_busy, in_xfer && (in_command == rarp_pkg::OP_QUERY), !in_ready, "query did not hold the input")

endmodule

bind range_add_range_predecessor rarp_checker u_rarp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_command (in_if.command),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_answer (out_if.answer),
  .out_found  (out_if.found)
);
